/* sv/blr_pkg.sv */
package blr_pkg;

   // Endpoint and point coordinate width; the walker carries one guard bit more.
   localparam int COORD_BITS   = 13;
   localparam int WALK_BITS    = COORD_BITS + 1;
   localparam int DIM_BITS     = 13;
   localparam int ERR_BITS     = COORD_BITS + 2;
   localparam int ADDR_BITS    = 24;
   localparam int PROD_BITS    = COORD_BITS + DIM_BITS + 1;
   localparam int COLOR_BITS   = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = DIM_BITS'(480);

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      SIGN_NONE  = 2'b00,
      SIGN_PLUS  = 2'b01,
      SIGN_MINUS = 2'b11
   } sign_type;

   typedef struct packed {
      cmd_type                 command;
      logic [COORD_BITS-1:0]   start_x;
      logic [COORD_BITS-1:0]   start_y;
      logic [COORD_BITS-1:0]   end_x;
      logic [COORD_BITS-1:0]   end_y;
      logic [COLOR_BITS-1:0]   line_color;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]   point_x;
      logic [COORD_BITS-1:0]   point_y;
      logic [ADDR_BITS-1:0]    pixel_address;
      logic [COLOR_BITS-1:0]   pixel_color;
      logic                    in_frame;
      logic                    line_active;
      logic                    last_point;
   } rsp_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] frame_width;
      logic [DIM_BITS-1:0] frame_height;
   } cfg_type;

   // Step of one axis for a sign code, as a walker-wide signed value.
   function automatic logic signed [WALK_BITS-1:0] sign_step(input logic [1:0] code);
      logic signed [WALK_BITS-1:0] step;
      unique case (code)
         SIGN_PLUS:  step = WALK_BITS'(1);
         SIGN_MINUS: step = '1;
         default:    step = '0;
      endcase
      return step;
   endfunction

   function automatic sign_type sign_of(input logic signed [WALK_BITS-1:0] d);
      sign_type s;
      if (d == '0) begin
         s = SIGN_NONE;
      end else if (d[WALK_BITS-1]) begin
         s = SIGN_MINUS;
      end else begin
         s = SIGN_PLUS;
      end
      return s;
   endfunction

endpackage

/* sv/bresenham_line_rasterizer.sv */
// Bresenham line rasterizer for all eight octants.
// Input channel req_*: a start transaction (command 0) loads both endpoints and
// the color and produces no result; a step transaction (command 1) produces one
// result on rsp_*: the next point, its frame address y*width+x (low 24 bits,
// zero when outside), the color, the in_frame flag and the last_point mark.
// A step while no line is active returns a result with line_active low and all
// other fields zero. A start while a line is active replaces that line.
// Frame width and height are set over the csr_* port (byte addresses 0 and 4).
// Step results are registered. Throughput: one transaction per cycle while
// req_stall is low; the per-point error update and the single address
// multiplier sit between the line state and the result register. A two-entry
// output buffer (result register plus skid entry) keeps the input open when
// rsp_stall rises; req_stall is high while the skid entry is held and falls
// once the receiver takes the result.
// Reset clears the line state (no line active), empties the output buffer and
// sets width 640 and height 480.
module bresenham_line_rasterizer import blr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type cfg;
   logic    accept;
   logic    push;
   logic    full;
   rsp_type result;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   blr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   blr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .push   (push),
      .result (result)
   );

   blr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_push   (push),
      .in_data   (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/blr_csr.sv */
module blr_csr import blr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   reg_index_type       index;
   logic                wr_en;

   assign index      = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (index)
            REG_FRAME_WIDTH:  width_in  = csr_pwdata[DIM_BITS-1:0];
            REG_FRAME_HEIGHT: height_in = csr_pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.frame_width  = width_ff;
   assign cfg.frame_height = height_ff;

endmodule

/* sv/blr_core.sv */
module blr_core import blr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  cfg_type cfg,
   output logic    push,
   output rsp_type result
);

   logic signed [WALK_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [WALK_BITS-1:0] cur_y_ff, cur_y_in;
   logic [ERR_BITS-1:0]         error_acc_ff, error_acc_in;
   logic [COORD_BITS-1:0]       long_span_ff, long_span_in;
   logic [COORD_BITS-1:0]       short_span_ff, short_span_in;
   logic [COORD_BITS-1:0]       steps_left_ff, steps_left_in;
   sign_type                    diag_x_ff, diag_x_in, diag_y_ff, diag_y_in;
   sign_type                    axis_x_ff, axis_x_in, axis_y_ff, axis_y_in;
   logic [COLOR_BITS-1:0]       held_color_ff, held_color_in;
   logic                        busy_ff, busy_in;

   logic signed [WALK_BITS-1:0] x0, y0, dx, dy, ax, ay;
   sign_type                    sx, sy;
   logic [COORD_BITS-1:0]       span_x, span_y;
   logic [ERR_BITS-1:0]         err_sum;
   logic                        wrap;
   logic                        in_bounds;
   logic                        last;
   logic [PROD_BITS-1:0]        addr_sum;

   // Setup arithmetic for a start transaction.
   always_comb begin
      x0 = {req.start_x[COORD_BITS-1], req.start_x};
      y0 = {req.start_y[COORD_BITS-1], req.start_y};
      dx = {req.end_x[COORD_BITS-1], req.end_x} - x0;
      dy = {req.end_y[COORD_BITS-1], req.end_y} - y0;
      ax = dx[WALK_BITS-1] ? -dx : dx;
      ay = dy[WALK_BITS-1] ? -dy : dy;
      span_x = ax[COORD_BITS-1:0];
      span_y = ay[COORD_BITS-1:0];
      sx = sign_of(dx);
      sy = sign_of(dy);
   end

   // Point emission and error update for a step transaction.
   always_comb begin
      err_sum   = error_acc_ff + ERR_BITS'(short_span_ff);
      wrap      = err_sum >= ERR_BITS'(long_span_ff);
      last      = steps_left_ff == '0;
      in_bounds = !cur_x_ff[WALK_BITS-1] && !cur_y_ff[WALK_BITS-1] &&
                  (cur_x_ff[COORD_BITS-1:0] < cfg.frame_width) &&
                  (cur_y_ff[COORD_BITS-1:0] < cfg.frame_height);
      addr_sum  = PROD_BITS'(cur_y_ff[COORD_BITS-1:0]) * PROD_BITS'(cfg.frame_width)
                  + PROD_BITS'(cur_x_ff[COORD_BITS-1:0]);
   end

   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      error_acc_in  = error_acc_ff;
      long_span_in  = long_span_ff;
      short_span_in = short_span_ff;
      steps_left_in = steps_left_ff;
      diag_x_in     = diag_x_ff;
      diag_y_in     = diag_y_ff;
      axis_x_in     = axis_x_ff;
      axis_y_in     = axis_y_ff;
      held_color_in = held_color_ff;
      busy_in       = busy_ff;
      push          = 1'b0;
      result        = '0;

      if (accept) begin
         unique case (req.command)
            CMD_START: begin
               diag_x_in = sx;
               diag_y_in = sy;
               // On equal spans y is the long axis, which makes the line diagonal.
               if (span_x > span_y) begin
                  long_span_in  = span_x;
                  short_span_in = span_y;
                  axis_x_in     = sx;
                  axis_y_in     = SIGN_NONE;
               end else begin
                  long_span_in  = span_y;
                  short_span_in = span_x;
                  axis_x_in     = SIGN_NONE;
                  axis_y_in     = sy;
               end
               cur_x_in      = x0;
               cur_y_in      = y0;
               error_acc_in  = ERR_BITS'(long_span_in >> 1);
               steps_left_in = long_span_in;
               held_color_in = req.line_color;
               busy_in       = 1'b1;
            end
            CMD_STEP: begin
               push = 1'b1;
               if (busy_ff) begin
                  result.point_x       = cur_x_ff[COORD_BITS-1:0];
                  result.point_y       = cur_y_ff[COORD_BITS-1:0];
                  result.pixel_address = in_bounds ? addr_sum[ADDR_BITS-1:0] : '0;
                  result.pixel_color   = held_color_ff;
                  result.in_frame      = in_bounds;
                  result.line_active   = 1'b1;
                  result.last_point    = last;
                  if (wrap) begin
                     error_acc_in = err_sum - ERR_BITS'(long_span_ff);
                     cur_x_in     = cur_x_ff + sign_step(diag_x_ff);
                     cur_y_in     = cur_y_ff + sign_step(diag_y_ff);
                  end else begin
                     error_acc_in = err_sum;
                     cur_x_in     = cur_x_ff + sign_step(axis_x_ff);
                     cur_y_in     = cur_y_ff + sign_step(axis_y_ff);
                  end
                  if (last) begin
                     busy_in = 1'b0;
                  end else begin
                     steps_left_in = steps_left_ff - 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         error_acc_ff  <= '0;
         long_span_ff  <= '0;
         short_span_ff <= '0;
         steps_left_ff <= '0;
         diag_x_ff     <= SIGN_NONE;
         diag_y_ff     <= SIGN_NONE;
         axis_x_ff     <= SIGN_NONE;
         axis_y_ff     <= SIGN_NONE;
         held_color_ff <= '0;
         busy_ff       <= 1'b0;
      end else begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         error_acc_ff  <= error_acc_in;
         long_span_ff  <= long_span_in;
         short_span_ff <= short_span_in;
         steps_left_ff <= steps_left_in;
         diag_x_ff     <= diag_x_in;
         diag_y_ff     <= diag_y_in;
         axis_x_ff     <= axis_x_in;
         axis_y_ff     <= axis_y_in;
         held_color_ff <= held_color_in;
         busy_ff       <= busy_in;
      end
   end

   a_err_below_span: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (error_acc_ff < ERR_BITS'(long_span_ff) || long_span_ff == '0))
      else $error("error term not below long span");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (push && result.last_point) |=> !busy_ff)
      else $error("line still active after its last point");

   a_idle_result_clean: assert property (@(posedge clock) disable iff (reset)
      (push && !busy_ff) |-> (result == '0))
      else $error("idle step result carries data");

endmodule

/* sv/blr_skid.sv */
module blr_skid import blr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_push,
   input  rsp_type in_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         // The input side is stalled while the skid entry is occupied.
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_push;
            out_data_in  = in_data;
         end
      end else if (in_push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(in_push && skid_valid_ff))
      else $error("result pushed into a full buffer");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import blr_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 250;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int PRINT_LIMIT   = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   bresenham_line_rasterizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type pending_commands[$];
   rsp_type expected_points[$];
   rsp_type expected_point;

   int   send_idle_pct  = 0;
   int   rsp_stall_pct  = 0;
   int   accepted_count = 0;
   int   mismatch_count = 0;
   int   cycle_count    = 0;
   logic hold_rsp       = 1'b0;

   // Frame size as the block should currently see it.
   logic [DIM_BITS-1:0] frame_w = FRAME_WIDTH_RESET;
   logic [DIM_BITS-1:0] frame_h = FRAME_HEIGHT_RESET;

   // Line walker state, mirrored at the block's widths.
   logic signed [WALK_BITS-1:0] walk_x      = '0;
   logic signed [WALK_BITS-1:0] walk_y      = '0;
   logic [ERR_BITS-1:0]         walk_error  = '0;
   logic [COORD_BITS-1:0]       major_span  = '0;
   logic [COORD_BITS-1:0]       minor_span  = '0;
   logic [COORD_BITS-1:0]       points_left = '0;
   sign_type                    diag_x      = SIGN_NONE;
   sign_type                    diag_y      = SIGN_NONE;
   sign_type                    axis_x      = SIGN_NONE;
   sign_type                    axis_y      = SIGN_NONE;
   logic [COLOR_BITS-1:0]       walk_color  = '0;
   logic                        line_busy   = 1'b0;

   function automatic sign_type direction(input int d);
      if (d > 0) return SIGN_PLUS;
      if (d < 0) return SIGN_MINUS;
      return SIGN_NONE;
   endfunction

   function automatic logic signed [WALK_BITS-1:0] unit_step(input sign_type s);
      case (s)
         SIGN_PLUS:  return WALK_BITS'(1);
         SIGN_MINUS: return -WALK_BITS'(1);
         default:    return '0;
      endcase
   endfunction

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < -4096) return -4096;
      if (v > 4095) return 4095;
      return v;
   endfunction

   task automatic rasterize_command(input req_type cmd);
      int                  x0, y0, dx, dy, adx, ady, xi, yi;
      rsp_type             point;
      sign_type            step_x, step_y;
      logic [ERR_BITS-1:0] err_sum;
      if (cmd.command == CMD_START) begin
         x0  = $signed(cmd.start_x);
         y0  = $signed(cmd.start_y);
         dx  = $signed(cmd.end_x) - x0;
         dy  = $signed(cmd.end_y) - y0;
         adx = magnitude(dx);
         ady = magnitude(dy);
         diag_x = direction(dx);
         diag_y = direction(dy);
         // A tie makes y the major axis.
         if (adx > ady) begin
            major_span = COORD_BITS'(adx);
            minor_span = COORD_BITS'(ady);
            axis_x = diag_x;
            axis_y = SIGN_NONE;
         end else begin
            major_span = COORD_BITS'(ady);
            minor_span = COORD_BITS'(adx);
            axis_x = SIGN_NONE;
            axis_y = diag_y;
         end
         walk_x      = WALK_BITS'(x0);
         walk_y      = WALK_BITS'(y0);
         walk_error  = ERR_BITS'(major_span >> 1);
         points_left = major_span;
         walk_color  = cmd.line_color;
         line_busy   = 1'b1;
      end else begin
         point = '0;
         if (line_busy) begin
            xi = walk_x;
            yi = walk_y;
            point.point_x     = walk_x[COORD_BITS-1:0];
            point.point_y     = walk_y[COORD_BITS-1:0];
            point.in_frame    = xi >= 0 && xi < int'(frame_w) && yi >= 0 && yi < int'(frame_h);
            if (point.in_frame) begin
               point.pixel_address = ADDR_BITS'(yi * int'(frame_w) + xi);
            end
            point.pixel_color = walk_color;
            point.line_active = 1'b1;
            point.last_point  = (points_left == '0);
            err_sum = walk_error + minor_span;
            if (err_sum >= major_span) begin
               walk_error = err_sum - major_span;
               step_x = diag_x;
               step_y = diag_y;
            end else begin
               walk_error = err_sum;
               step_x = axis_x;
               step_y = axis_y;
            end
            walk_x = walk_x + unit_step(step_x);
            walk_y = walk_y + unit_step(step_y);
            if (point.last_point) begin
               line_busy = 1'b0;
            end else begin
               points_left = points_left - 1'b1;
            end
         end
         expected_points.insert(expected_points.size(), point);
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
      end
   endtask

   // Driver: offers the next pending command once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         line_busy = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            rasterize_command(req_data);
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_commands.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_commands.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Monitor: every taken result is matched against the oldest expected point.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report_mismatch("result with no point expected");
         end else begin
            expected_point = expected_points.pop_front();
            check_field("point_x", 32'(rsp_data.point_x), 32'(expected_point.point_x));
            check_field("point_y", 32'(rsp_data.point_y), 32'(expected_point.point_y));
            check_field("pixel_address", 32'(rsp_data.pixel_address),
                        32'(expected_point.pixel_address));
            check_field("pixel_color", rsp_data.pixel_color, expected_point.pixel_color);
            check_field("in_frame", 32'(rsp_data.in_frame), 32'(expected_point.in_frame));
            check_field("line_active", 32'(rsp_data.line_active),
                        32'(expected_point.line_active));
            check_field("last_point", 32'(rsp_data.last_point),
                        32'(expected_point.last_point));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Long receiver hold-off early in the first random phase, so the output
   // buffer fills and the input side has to stall.
   initial begin
      wait (accepted_count >= 60);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   task automatic csr_write(input reg_index_type idx, input logic [DIM_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(4 * int'(idx));
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_FRAME_WIDTH) begin
         frame_w = value;
      end else begin
         frame_h = value;
      end
      // Read the register back right away.
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field($sformatf("register %s readback", idx.name()),
                  csr_prdata, CSR_DATA_BITS'(value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic req_type random_command(input cmd_type kind);
      req_type c;
      c.command    = kind;
      c.start_x    = COORD_BITS'($urandom);
      c.start_y    = COORD_BITS'($urandom);
      c.end_x      = COORD_BITS'($urandom);
      c.end_y      = COORD_BITS'($urandom);
      c.line_color = $urandom;
      return c;
   endfunction

   task automatic queue_start(input int x0, input int y0, input int x1, input int y1,
                              input logic [COLOR_BITS-1:0] color);
      req_type c;
      c = random_command(CMD_START);
      c.start_x    = COORD_BITS'(x0);
      c.start_y    = COORD_BITS'(y0);
      c.end_x      = COORD_BITS'(x1);
      c.end_y      = COORD_BITS'(y1);
      c.line_color = color;
      pending_commands.insert(pending_commands.size(), c);
   endtask

   task automatic queue_steps(input int count);
      for (int k = 0; k < count; k++) begin
         pending_commands.insert(pending_commands.size(), random_command(CMD_STEP));
      end
   endtask

   // One line with random content: mostly walked to its end, sometimes cut
   // short by the next start, sometimes stepped past its end.
   task automatic queue_line(output int pushed);
      int x0, y0, x1, y1, reach, span, steps;
      if ($urandom_range(3) == 0) begin
         x0 = $urandom_range(8191) - 4096;
         y0 = $urandom_range(8191) - 4096;
      end else begin
         x0 = clamp_coord(int'($urandom_range(int'(frame_w) + 8)) - 4);
         y0 = clamp_coord(int'($urandom_range(int'(frame_h) + 8)) - 4);
      end
      reach = ($urandom_range(31) == 0) ? 100 : 10;
      x1 = clamp_coord(x0 + int'($urandom_range(2 * reach)) - reach);
      y1 = clamp_coord(y0 + int'($urandom_range(2 * reach)) - reach);
      span = magnitude(x1 - x0);
      if (magnitude(y1 - y0) > span) span = magnitude(y1 - y0);
      steps = span + 1;
      case ($urandom_range(7))
         0:       steps = $urandom_range(span);
         1:       steps = steps + $urandom_range(1, 2);
         default: ;
      endcase
      queue_start(x0, y0, x1, y1, $urandom);
      queue_steps(steps);
      pushed = steps + 1;
   endtask

   task automatic wait_drained();
      while (pending_commands.size() != 0 || req_valid || expected_points.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                  queued, pushed;
      logic [DIM_BITS-1:0] widths[6];
      logic [DIM_BITS-1:0] heights[6];
      widths  = '{13'd4096, 13'd1, 13'd8191, 13'd0,   13'd300, 13'd0};
      heights = '{13'd4096, 13'd1, 13'd4096, 13'd300, 13'd0,   13'd0};
      widths[5]  = DIM_BITS'($urandom_range(1, 4096));
      heights[5] = DIM_BITS'($urandom_range(1, 4096));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed lines at the reset frame size of 640 by 480.
      queue_steps(1);                                         // step with no line active
      queue_start(0, 0, 0, 0, 32'hFFFF_FFFF);                 // single point line
      queue_steps(2);
      queue_start(-4096, -4096, 4095, 4095, 32'h0000_0000);   // full range, then dropped
      queue_steps(2);
      queue_start(4095, -4096, -4096, 4095, 32'hA5A5_5A5A);   // replaced while busy
      queue_steps(1);
      queue_start(10, 10, 13, 7, 32'h1234_5678);              // equal spans
      queue_steps(4);
      queue_start(638, 478, 642, 479, 32'h0F0F_F0F0);         // crosses the right edge
      queue_steps(5);
      queue_start(1, 2, 0, -1, 32'h8000_0001);                // steep, crosses top edge
      queue_steps(4);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         csr_write(REG_FRAME_WIDTH, widths[p]);
         csr_write(REG_FRAME_HEIGHT, heights[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 76; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 76; end
            default: begin send_idle_pct = 34; rsp_stall_pct = 34; end
         endcase
         queued = 0;
         while (queued < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) begin
               pending_commands.insert(pending_commands.size(),
                                       random_command(cmd_type'($urandom_range(1))));
               queued++;
            end else begin
               queue_line(pushed);
               queued += pushed;
            end
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (expected_points.size() != 0) begin
         report_mismatch($sformatf("%0d points never arrived", expected_points.size()));
      end
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/blr_pkg.sv
sv/blr_csr.sv
sv/blr_core.sv
sv/blr_skid.sv
sv/bresenham_line_rasterizer.sv
test/testbench.sv
